/* rtl/core/rc4sc_pkg.sv */
// rc4sc_pkg: shared types and constants of the rc4 stream cipher unit
// beat structs, memory request, controller result, register indexes
// no dependencies
package rc4sc_pkg;

    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = 8;
    localparam int KEY_MAX_BYTES = 16;
    localparam int KEY_IDX_W     = 4;
    localparam int KEY_W         = 128;
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [PERM_AW-1:0]   PERM_LAST   = PERM_AW'(PERM_DEPTH - 1);
    localparam logic [KEY_LEN_W-1:0] KEY_MAX_LEN = KEY_LEN_W'(KEY_MAX_BYTES);
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = KEY_LEN_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] result_byte;
        logic [7:0] keystream_byte;
    } t_out_beat;

    typedef struct packed {
        logic [PERM_AW-1:0] rd_addr;
        logic               wr_en;
        logic [PERM_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } t_mem_req;

    typedef struct packed {
        logic       done;
        logic [7:0] data;
        logic [7:0] ks;
    } t_ks_res;

endpackage

/* rtl/core/rc4sc_perm_ram.sv */
// rc4sc_perm_ram: 256 x 8 permutation memory, one write and one read port
// read data registered, old data returned on a same-address write
// depends on rc4sc_pkg
module rc4sc_perm_ram (
    input  logic               i_clk,
    input  rc4sc_pkg::t_mem_req i_req,
    output logic [7:0]         o_rd_data
);
    import rc4sc_pkg::*;

    logic [7:0] r_mem [PERM_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/rc4sc_ctrl.sv */
// rc4sc_ctrl: sequencer for key schedule and keystream generation
// drives the permutation memory through read-modify-write steps
// depends on rc4sc_pkg
module rc4sc_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rc4sc_pkg::t_in_beat                  i_in_data,
    input  logic [rc4sc_pkg::KEY_W-1:0]          i_key,
    input  logic [rc4sc_pkg::KEY_LEN_W-1:0]      i_key_len,
    input  logic                                 i_out_free,
    input  logic [7:0]                           i_rd_data,
    output rc4sc_pkg::t_mem_req                  o_req,
    output rc4sc_pkg::t_ks_res                   o_res
);
    import rc4sc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCH_RDN,
        ST_SCH_RDJ,
        ST_SCH_WRN,
        ST_SCH_WRJ,
        ST_KS_RDI,
        ST_KS_RDJ,
        ST_KS_SWAP,
        ST_KS_OUT
    } t_state;

    t_state               r_state, n_state;
    logic [PERM_AW-1:0]   r_n, n_n;
    logic [PERM_AW-1:0]   r_i, n_i;
    logic [PERM_AW-1:0]   r_j, n_j;
    logic [PERM_AW-1:0]   r_t, n_t;
    logic [7:0]           r_sa, n_sa;
    logic [7:0]           r_sb, n_sb;
    logic [7:0]           r_data, n_data;
    logic [KEY_IDX_W-1:0] r_k, n_k;
    logic                 r_keyed, n_keyed;

    logic [KEY_LEN_W-1:0] eff_len;
    logic                 key_last;
    logic [7:0]           key_byte;
    logic [PERM_AW-1:0]   j_sum;
    logic [PERM_AW-1:0]   t_sum;
    logic [7:0]           ks;

    // zero length counts as one byte, longer than the key clamps
    always_comb begin
        if (i_key_len == '0) begin
            eff_len = KEY_LEN_W'(1);
        end else if (i_key_len > KEY_MAX_LEN) begin
            eff_len = KEY_MAX_LEN;
        end else begin
            eff_len = i_key_len;
        end
    end

    assign key_last = ({1'b0, r_k} == (eff_len - KEY_LEN_W'(1)));
    assign key_byte = i_key[{r_k, 3'b000} +: 8];

    // swap of S[i] and S[j] lands around the final read, patch it up here
    always_comb begin
        if (r_t == r_j) begin
            ks = r_sa;
        end else if (r_t == r_i) begin
            ks = r_sb;
        end else begin
            ks = i_rd_data;
        end
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_data  = r_data;
        n_k     = r_k;
        n_keyed = r_keyed;
        j_sum   = r_j + i_rd_data;
        t_sum   = r_sa + i_rd_data;

        o_in_ready    = 1'b0;
        o_req         = '0;
        o_req.rd_addr = r_i + 8'd1;
        o_res         = '0;
        o_res.ks      = ks;
        o_res.data    = r_data;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_data = i_in_data.data_byte;
                    if (i_in_data.first_of_message || !r_keyed) begin
                        n_n     = '0;
                        n_state = ST_FILL;
                    end else begin
                        // read of S[i+1] already issued this cycle
                        n_i     = r_i + 8'd1;
                        n_state = ST_KS_RDJ;
                    end
                end
            end
            ST_FILL: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = r_n;
                o_req.wr_data = r_n;
                n_n           = r_n + 8'd1;
                if (r_n == PERM_LAST) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_SCH_RDN;
                end
            end
            ST_SCH_RDN: begin
                o_req.rd_addr = r_n;
                n_state       = ST_SCH_RDJ;
            end
            ST_SCH_RDJ: begin
                j_sum         = r_j + i_rd_data + key_byte;
                o_req.rd_addr = j_sum;
                n_j           = j_sum;
                n_sa          = i_rd_data;
                n_state       = ST_SCH_WRN;
            end
            ST_SCH_WRN: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = r_n;
                o_req.wr_data = i_rd_data;
                n_state       = ST_SCH_WRJ;
            end
            ST_SCH_WRJ: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = r_j;
                o_req.wr_data = r_sa;
                n_k           = key_last ? '0 : r_k + 4'd1;
                n_n           = r_n + 8'd1;
                if (r_n == PERM_LAST) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_keyed = 1'b1;
                    n_state = ST_KS_RDI;
                end else begin
                    n_state = ST_SCH_RDN;
                end
            end
            ST_KS_RDI: begin
                n_i     = r_i + 8'd1;
                n_state = ST_KS_RDJ;
            end
            ST_KS_RDJ: begin
                o_req.rd_addr = j_sum;
                n_j           = j_sum;
                n_sa          = i_rd_data;
                n_state       = ST_KS_SWAP;
            end
            ST_KS_SWAP: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = r_i;
                o_req.wr_data = i_rd_data;
                o_req.rd_addr = t_sum;
                n_t           = t_sum;
                n_sb          = i_rd_data;
                n_state       = ST_KS_OUT;
            end
            ST_KS_OUT: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = r_j;
                o_req.wr_data = r_sa;
                o_req.rd_addr = r_t;
                if (i_out_free) begin
                    o_res.done = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_keyed <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_keyed <= n_keyed;
        end
        r_n    <= n_n;
        r_t    <= n_t;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_data <= n_data;
        r_k    <= n_k;
    end

endmodule

/* rtl/core/rc4_stream_cipher_unit.sv */
// rc4_stream_cipher_unit: byte-wide rc4 cipher, top level
// key registers, output register, sequencer and permutation memory
// depends on rc4sc_pkg, rc4sc_ctrl, rc4sc_perm_ram
//
//   channel  dir  handshake                 beat
//   in       in   i_in_valid / o_in_ready   i_in_data  (t_in_beat)
//   out      out  o_out_valid / i_out_ready o_out_data (t_out_beat)
//   cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a keystream byte takes three reads and two swap writes, which share the
// one read port and one write port of the permutation memory
// a beat flagged first of message, and the first beat after reset, first runs
// the key schedule: 256 fill writes, 256 schedule steps of 4 memory accesses,
// then a read of S[1]
// the next input beat is taken while a result still waits in the output
// register; a second result stalls the sequencer until the register drains
module rc4_stream_cipher_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rc4sc_pkg::t_in_beat                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rc4sc_pkg::t_out_beat                o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rc4sc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rc4sc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rc4sc_pkg::*;

    logic [CFG_DATA_W-1:0] r_key_lo;
    logic [CFG_DATA_W-1:0] r_key_hi;
    logic [KEY_LEN_W-1:0]  r_key_len;
    logic                  r_out_valid;
    t_out_beat             r_out;

    t_mem_req              mem_req;
    t_ks_res               ctrl_res;
    logic [7:0]            rd_data;
    logic                  out_free;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= KEY_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_LOW:  r_key_lo  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_hi  <= i_cfg_data;
                CFG_KEY_LEN:  r_key_len <= i_cfg_data[KEY_LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    rc4sc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_key      ({r_key_hi, r_key_lo}),
        .i_key_len  (r_key_len),
        .i_out_free (out_free),
        .i_rd_data  (rd_data),
        .o_req      (mem_req),
        .o_res      (ctrl_res)
    );

    rc4sc_perm_ram u_perm_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_res.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (ctrl_res.done) begin
            r_out.result_byte    <= ctrl_res.data ^ ctrl_res.ks;
            r_out.keystream_byte <= ctrl_res.ks;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer took a second beat without finishing the first");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_res.done |-> (!r_out_valid || i_out_ready))
        else $error("result written over a beat not yet taken");

    a_out_from_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(ctrl_res.done))
        else $error("output valid raised without a finished keystream step");
`endif

endmodule
